// ===== src/rhl_pkg.sv =====
// shared types and constants for the random hyperplane hash unit
`timescale 1ns / 1ps
`default_nettype none
package rhl_pkg;

    localparam int DEF_MAX_DIM    = 64;
    localparam int DEF_MAX_TABLES = 4;
    localparam int DEF_MAX_BITS   = 16;

    localparam int VAL_W  = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 38;
    localparam int HASH_W = 16;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_DIM_IN_USE    = 2'd0,
        REG_TABLES_IN_USE = 2'd1,
        REG_BITS_IN_USE   = 2'd2,
        REG_NONE          = 2'd3
    } reg_idx_t;

    localparam logic [6:0] DIM_RESET    = 7'd64;
    localparam logic [3:0] TABLES_RESET = 4'd4;
    localparam logic [4:0] BITS_RESET   = 5'd16;

    localparam logic KIND_WEIGHT  = 1'b0;
    localparam logic KIND_ELEMENT = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [2:0]         table_index;
        logic [3:0]         bit_index;
        logic [5:0]         dim_index;
        logic signed [15:0] value;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  out_table;
        logic [15:0] hash;
        logic        last_of_run;
    } out_item_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic we;     // weight write into this cell's column
        logic re;     // weight read for one table
        logic mul;    // read data valid, form product
        logic acc;    // product valid, accumulate and rotate
        logic shift;  // rotate ring while hashes go out
        logic clr;    // clear all accumulators
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== src/rhl_in_if.sv =====
// input channel interface
`timescale 1ns / 1ps
`default_nettype none
interface rhl_in_if;
    logic               valid;
    logic               ready;
    rhl_pkg::in_item_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/rhl_out_if.sv =====
// output channel interface
`timescale 1ns / 1ps
`default_nettype none
interface rhl_out_if;
    logic               valid;
    logic               ready;
    rhl_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/rhl_ram.sv =====
// generic single-write, registered-read ram
`timescale 1ns / 1ps
`default_nettype none
module rhl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== src/rhl_cell.sv =====
// one hash-bit cell: weight column, multiplier and accumulator ring over tables
`timescale 1ns / 1ps
`default_nettype none
module rhl_cell #(
    parameter int RING_LEN = rhl_pkg::DEF_MAX_TABLES,
    parameter int DEPTH    = rhl_pkg::DEF_MAX_TABLES * rhl_pkg::DEF_MAX_DIM
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire rhl_pkg::cell_ctrl_t                   ctrl,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    input  wire logic signed [rhl_pkg::VAL_W-1:0]      wdata,
    input  wire logic signed [rhl_pkg::VAL_W-1:0]      elem,
    output logic                                       nonneg
);
    localparam logic signed [rhl_pkg::ACC_W:0] SAT_MAX =
        (rhl_pkg::ACC_W+1)'((64'sd1 <<< (rhl_pkg::ACC_W-1)) - 64'sd1);
    localparam logic signed [rhl_pkg::ACC_W:0] SAT_MIN =
        (rhl_pkg::ACC_W+1)'(-(64'sd1 <<< (rhl_pkg::ACC_W-1)));

    logic [rhl_pkg::VAL_W-1:0]         rdata;
    logic signed [rhl_pkg::PROD_W-1:0] prod_reg;
    logic signed [rhl_pkg::ACC_W-1:0]  acc_reg [RING_LEN];
    logic signed [rhl_pkg::ACC_W:0]    sum;
    logic signed [rhl_pkg::ACC_W-1:0]  head_next;

    rhl_ram #(.WIDTH(rhl_pkg::VAL_W), .DEPTH(DEPTH)) u_col (
        .clk   (clk),
        .we    (ctrl.we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (ctrl.re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.mul)
        begin
            prod_reg <= $signed(rdata) * elem;
        end
    end

    // exact add with saturation at the 38-bit limits
    always_comb
    begin
        sum = (rhl_pkg::ACC_W+1)'(acc_reg[0]) + (rhl_pkg::ACC_W+1)'(prod_reg);
        if (sum > SAT_MAX)
        begin
            head_next = rhl_pkg::ACC_W'(SAT_MAX);
        end
        else if (sum < SAT_MIN)
        begin
            head_next = rhl_pkg::ACC_W'(SAT_MIN);
        end
        else
        begin
            head_next = rhl_pkg::ACC_W'(sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RING_LEN; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else if (ctrl.clr)
        begin
            for (int i = 0; i < RING_LEN; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else if (ctrl.acc || ctrl.shift)
        begin
            for (int i = 0; i < RING_LEN - 1; i++)
            begin
                acc_reg[i] <= acc_reg[i+1];
            end
            acc_reg[RING_LEN-1] <= ctrl.acc ? head_next : acc_reg[0];
        end
    end

    assign nonneg = ~acc_reg[0][rhl_pkg::ACC_W-1];
endmodule
`default_nettype wire

// ===== src/random_hyperplane_lsh_hash_unit.sv =====
// top level of the random hyperplane (simhash) hash unit
`timescale 1ns / 1ps
`default_nettype none
// Sign-random-projection hashing. Weight transfers (kind 0) store one Q1.15
// hyperplane weight per table, bit and dimension, one per cycle while idle.
// Element transfers (kind 1) are multiply-accumulated against every
// hyperplane: a row of MAX_BITS cells, one per hash bit, each owns a weight
// column ram, one 16x16 multiplier and a ring of MAX_TABLES 38-bit
// saturating accumulators. One table is read per cycle, so an element in
// range holds the input while all MAX_TABLES tables are issued and then
// while the pipeline drains (multiply, accumulate, empty check). An element
// outside dim_in_use is not accumulated. On an element with last set, one
// hash per table in use goes out, one per cycle as the output register
// frees, then the accumulators clear. The output register lets the next
// input be taken while the final hash still waits.
module random_hyperplane_lsh_hash_unit #(
    parameter int MAX_DIM    = rhl_pkg::DEF_MAX_DIM,
    parameter int MAX_TABLES = rhl_pkg::DEF_MAX_TABLES,
    parameter int MAX_BITS   = rhl_pkg::DEF_MAX_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    rhl_in_if.sink                               in_ch,
    rhl_out_if.source                            out_ch,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [rhl_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [rhl_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [rhl_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready
);
    localparam int DEPTH = MAX_TABLES * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MAC   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [6:0] dim_in_use_reg;
    logic [3:0] tables_in_use_reg;
    logic [4:0] bits_in_use_reg;
    rhl_pkg::reg_idx_t cfg_idx;

    // latched element
    logic [5:0]                        dim_reg;
    logic signed [rhl_pkg::VAL_W-1:0]  elem_reg;
    logic                              last_reg;

    logic [TW-1:0] cnt_reg, cnt_next;
    logic          v1_reg, v2_reg;   // ram data valid, product valid

    logic              out_valid_reg;
    rhl_pkg::out_item_t out_data_reg;

    logic          in_fire, wt_fire, el_fire, el_in_range, wt_in_range;
    logic          emit_step, emit_last;
    logic [3:0]    nt;
    logic [AW-1:0] waddr, raddr;
    logic [MAX_BITS-1:0]        nonneg;
    logic [rhl_pkg::HASH_W-1:0] hash_now;
    rhl_pkg::cell_ctrl_t        base_ctrl;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = rhl_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        case (cfg_idx)
            rhl_pkg::REG_DIM_IN_USE:    prdata = 32'(dim_in_use_reg);
            rhl_pkg::REG_TABLES_IN_USE: prdata = 32'(tables_in_use_reg);
            rhl_pkg::REG_BITS_IN_USE:   prdata = 32'(bits_in_use_reg);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_in_use_reg    <= rhl_pkg::DIM_RESET;
            tables_in_use_reg <= rhl_pkg::TABLES_RESET;
            bits_in_use_reg   <= rhl_pkg::BITS_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (cfg_idx)
                rhl_pkg::REG_DIM_IN_USE:    dim_in_use_reg    <= pwdata[6:0];
                rhl_pkg::REG_TABLES_IN_USE: tables_in_use_reg <= pwdata[3:0];
                rhl_pkg::REG_BITS_IN_USE:   bits_in_use_reg   <= pwdata[4:0];
                default:                    ;
            endcase
        end
    end

    // ---------------- input side ----------------
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign wt_fire     = in_fire && (in_ch.data.kind == rhl_pkg::KIND_WEIGHT);
    assign el_fire     = in_fire && (in_ch.data.kind == rhl_pkg::KIND_ELEMENT);

    assign wt_in_range = (int'(in_ch.data.table_index) < MAX_TABLES)
                      && (int'(in_ch.data.bit_index) < MAX_BITS)
                      && (int'(in_ch.data.dim_index) < MAX_DIM);
    assign el_in_range = ({1'b0, in_ch.data.dim_index} < dim_in_use_reg)
                      && (int'(in_ch.data.dim_index) < MAX_DIM);

    // row address is table * MAX_DIM + dimension
    assign waddr = AW'(AW'(in_ch.data.table_index) * AW'(MAX_DIM))
                 + AW'(in_ch.data.dim_index);
    assign raddr = AW'(AW'(cnt_reg) * AW'(MAX_DIM)) + AW'(dim_reg);

    // tables in use clamped to 1..MAX_TABLES
    always_comb
    begin
        if (tables_in_use_reg == 4'd0)
        begin
            nt = 4'd1;
        end
        else if (int'(tables_in_use_reg) > MAX_TABLES)
        begin
            nt = 4'(MAX_TABLES);
        end
        else
        begin
            nt = tables_in_use_reg;
        end
    end

    assign emit_step = (state_reg == ST_EMIT) && (!out_valid_reg || out_ch.ready);
    assign emit_last = (4'(cnt_reg) + 4'd1 == nt);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (el_fire)
                begin
                    if (el_in_range)
                    begin
                        state_next = ST_MAC;
                    end
                    else if (in_ch.data.last)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_MAC:
            begin
                if (int'(cnt_reg) == MAX_TABLES - 1)
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + TW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (emit_step)
                begin
                    if (emit_last)
                    begin
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + TW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            v1_reg    <= (state_reg == ST_MAC);
            v2_reg    <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (el_fire)
        begin
            dim_reg  <= in_ch.data.dim_index;
            elem_reg <= in_ch.data.value;
            last_reg <= in_ch.data.last;
        end
    end

    // ---------------- cell row ----------------
    always_comb
    begin
        base_ctrl       = '0;
        base_ctrl.re    = (state_reg == ST_MAC);
        base_ctrl.mul   = v1_reg;
        base_ctrl.acc   = v2_reg;
        base_ctrl.shift = emit_step;
        // the whole ring has rotated back by the final hash only if all tables
        // were emitted, so the clear also restores alignment
        base_ctrl.clr   = emit_step && emit_last;
    end

    for (genvar b = 0; b < MAX_BITS; b++)
    begin : g_cell
        rhl_pkg::cell_ctrl_t ctrl;
        always_comb
        begin
            ctrl    = base_ctrl;
            ctrl.we = wt_fire && wt_in_range && (int'(in_ch.data.bit_index) == b);
        end

        rhl_cell #(.RING_LEN(MAX_TABLES), .DEPTH(DEPTH)) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .waddr  (waddr),
            .raddr  (raddr),
            .wdata  (in_ch.data.value),
            .elem   (elem_reg),
            .nonneg (nonneg[b])
        );
    end

    // hash bits at or above bits_in_use or beyond the cell row read as zero
    for (genvar h = 0; h < rhl_pkg::HASH_W; h++)
    begin : g_hash
        if (h < MAX_BITS)
        begin : g_used
            assign hash_now[h] = nonneg[h] && (5'(h) < bits_in_use_reg);
        end
        else
        begin : g_zero
            assign hash_now[h] = 1'b0;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_step)
        begin
            out_data_reg.out_table   <= 3'(cnt_reg);
            out_data_reg.hash        <= hash_now;
            out_data_reg.last_of_run <= emit_last;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;
endmodule
`default_nettype wire
